>>> design/cts_pkg.sv
// cts_pkg: shared types, codes and helper functions for the c-subset token scanner
// holds request structs, scanner context, token kinds, error codes and keyword constants
// no dependencies
`default_nettype none

package cts_pkg;

	localparam int POSITION_BITS = 24;
	localparam int COUNTER_BITS  = 16;
	localparam int KEYWORD_CHARS = 8;
	localparam int WINDOW_BITS   = 8 * KEYWORD_CHARS;
	localparam int KEYWORDS      = 8;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [COUNTER_BITS-1:0]  cnt_t;
	typedef logic [WINDOW_BITS-1:0]   window_t;
	typedef logic [4:0]               kind_t;
	typedef logic [2:0]               err_t;

	localparam pos_t POS_MAX = '1;
	localparam cnt_t CNT_MAX = '1;

	// token kinds
	localparam kind_t KIND_IDENT    = 5'd0;
	localparam kind_t KIND_KW_BASE  = 5'd1;
	localparam kind_t KIND_INT      = 5'd9;
	localparam kind_t KIND_FLOAT    = 5'd10;
	localparam kind_t KIND_STRING   = 5'd11;
	localparam kind_t KIND_DOT      = 5'd12;
	localparam kind_t KIND_ELLIPSIS = 5'd13;
	localparam kind_t KIND_NOTEQ    = 5'd14;
	localparam kind_t KIND_SINGLE   = 5'd15;
	localparam kind_t KIND_END      = 5'd31;

	// error codes
	localparam err_t ERR_NONE       = 3'd0;
	localparam err_t ERR_UNEXPECTED = 3'd1;
	localparam err_t ERR_DOUBLE_DOT = 3'd2;
	localparam err_t ERR_BANG       = 3'd3;
	localparam err_t ERR_OPEN_STR   = 3'd4;

	// characters with a role of their own
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_EQUAL   = 8'h3d;
	localparam logic [7:0] CH_UNDER   = 8'h5f;

	// keyword spellings, first character in the low byte, zero padded
	localparam window_t KW_WORD [KEYWORDS] = '{
		64'h00000074_736e6f63, // const
		64'h00006e72_75746572, // return
		64'h00000000_00006669, // if
		64'h00000065_6c696877, // while
		64'h00666564_65707974, // typedef
		64'h00007463_75727473, // struct
		64'h64656e67_69736e75, // unsigned
		64'h00000000_6d756e65  // enum
	};
	localparam cnt_t KW_LEN [KEYWORDS] = '{
		cnt_t'(5), cnt_t'(6), cnt_t'(2), cnt_t'(5),
		cnt_t'(7), cnt_t'(6), cnt_t'(8), cnt_t'(4)
	};

	typedef enum logic [7:0] {
		ST_INIT   = 8'b0000_0001,
		ST_IDENT  = 8'b0000_0010,
		ST_INT    = 8'b0000_0100,
		ST_FLOAT  = 8'b0000_1000,
		ST_STRING = 8'b0001_0000,
		ST_DOT    = 8'b0010_0000,
		ST_DOTDOT = 8'b0100_0000,
		ST_BANG   = 8'b1000_0000
	} scan_state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} src_req_t;

	typedef struct packed {
		kind_t      token_kind;
		pos_t       start_index;
		cnt_t       token_length;
		cnt_t       line_number;
		cnt_t       column_number;
		err_t       error_code;
		logic       last_of_run;
	} tok_req_t;

	typedef struct packed {
		scan_state_t scan_state;
		pos_t        pending_start;
		cnt_t        pending_length;
		cnt_t        pending_line;
		cnt_t        pending_column;
		window_t     keyword_window;
		pos_t        byte_position;
		cnt_t        line_counter;
		cnt_t        column_counter;
	} scan_ctx_t;

	typedef struct packed {
		logic [1:0] count;
		tok_req_t   first;
		tok_req_t   second;
	} scan_result_t;

	function automatic pos_t pos_inc(pos_t v);
		return (v == POS_MAX) ? POS_MAX : v + pos_t'(1);
	endfunction

	function automatic cnt_t cnt_inc(cnt_t v);
		return (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	// single-character token kind, KIND_IDENT when the byte is not one of them
	function automatic kind_t single_kind(logic [7:0] c);
		kind_t k;
		unique case (c)
			8'h28:   k = KIND_SINGLE + kind_t'(0);  // (
			8'h29:   k = KIND_SINGLE + kind_t'(1);  // )
			8'h7b:   k = KIND_SINGLE + kind_t'(2);  // {
			8'h7d:   k = KIND_SINGLE + kind_t'(3);  // }
			8'h2c:   k = KIND_SINGLE + kind_t'(4);  // ,
			8'h3b:   k = KIND_SINGLE + kind_t'(5);  // ;
			8'h2b:   k = KIND_SINGLE + kind_t'(6);  // +
			8'h3d:   k = KIND_SINGLE + kind_t'(7);  // =
			8'h2a:   k = KIND_SINGLE + kind_t'(8);  // *
			8'h26:   k = KIND_SINGLE + kind_t'(9);  // &
			8'h3c:   k = KIND_SINGLE + kind_t'(10); // <
			8'h3e:   k = KIND_SINGLE + kind_t'(11); // >
			8'h2d:   k = KIND_SINGLE + kind_t'(12); // -
			8'h5b:   k = KIND_SINGLE + kind_t'(13); // [
			8'h5d:   k = KIND_SINGLE + kind_t'(14); // ]
			8'h2f:   k = KIND_SINGLE + kind_t'(15); // /
			default: k = KIND_IDENT;
		endcase
		return k;
	endfunction

	// parallel keyword compare; bytes past the length are zero in the window
	function automatic kind_t keyword_kind(window_t w, cnt_t len);
		kind_t k;
		k = KIND_IDENT;
		for (int i = 0; i < KEYWORDS; i++) begin
			if (len == KW_LEN[i] && w == KW_WORD[i]) begin
				k = KIND_KW_BASE + kind_t'(i);
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

>>> design/cts_scan_core.sv
// cts_scan_core: one-pass scan of a request against the scanner context
// closes the pending token, rescans the byte from the initial state, updates counters
// depends on cts_pkg
`default_nettype none

module cts_scan_core (
	input  wire cts_pkg::scan_ctx_t    ctx,
	input  wire cts_pkg::src_req_t     item,
	output cts_pkg::scan_ctx_t         ctx_next,
	output cts_pkg::scan_result_t      result
);

	always_comb begin
		cts_pkg::scan_ctx_t nxt;
		cts_pkg::tok_req_t  close_r;
		cts_pkg::tok_req_t  init_r;
		cts_pkg::kind_t     sk;
		logic               has_close;
		logic               has_init;
		logic               rescan;
		logic [7:0]         c;

		c         = item.char_code;
		nxt       = ctx;
		has_close = 1'b0;
		has_init  = 1'b0;
		rescan    = 1'b0;
		sk        = cts_pkg::single_kind(c);

		close_r.token_kind    = cts_pkg::KIND_IDENT;
		close_r.start_index   = ctx.pending_start;
		close_r.token_length  = ctx.pending_length;
		close_r.line_number   = ctx.pending_line;
		close_r.column_number = ctx.pending_column;
		close_r.error_code    = cts_pkg::ERR_NONE;
		close_r.last_of_run   = 1'b0;

		init_r.token_kind    = cts_pkg::KIND_IDENT;
		init_r.start_index   = ctx.byte_position;
		init_r.token_length  = cts_pkg::cnt_t'(1);
		init_r.line_number   = ctx.line_counter;
		init_r.column_number = ctx.column_counter;
		init_r.error_code    = cts_pkg::ERR_NONE;
		init_r.last_of_run   = 1'b0;

		if (item.end_of_input) begin
			nxt.scan_state = cts_pkg::ST_INIT;
			has_close      = (ctx.scan_state != cts_pkg::ST_INIT);
			unique case (ctx.scan_state)
				cts_pkg::ST_IDENT:  close_r.token_kind = cts_pkg::keyword_kind(
					ctx.keyword_window, ctx.pending_length);
				cts_pkg::ST_INT:    close_r.token_kind = cts_pkg::KIND_INT;
				cts_pkg::ST_FLOAT:  close_r.token_kind = cts_pkg::KIND_FLOAT;
				cts_pkg::ST_STRING: close_r.error_code = cts_pkg::ERR_OPEN_STR;
				cts_pkg::ST_DOT:    close_r.token_kind = cts_pkg::KIND_DOT;
				cts_pkg::ST_DOTDOT: close_r.error_code = cts_pkg::ERR_DOUBLE_DOT;
				cts_pkg::ST_BANG:   close_r.error_code = cts_pkg::ERR_BANG;
				default: ;
			endcase
			// end token at the running counters
			has_init            = 1'b1;
			init_r.token_kind   = cts_pkg::KIND_END;
			init_r.token_length = '0;
		end else begin
			unique case (ctx.scan_state)
				cts_pkg::ST_IDENT: begin
					if (cts_pkg::is_alpha(c) || cts_pkg::is_digit(c) || c == cts_pkg::CH_UNDER) begin
						if (ctx.pending_length < cts_pkg::cnt_t'(cts_pkg::KEYWORD_CHARS)) begin
							nxt.keyword_window[8*ctx.pending_length[2:0] +: 8] = c;
						end
						nxt.pending_length = cts_pkg::cnt_inc(ctx.pending_length);
					end else begin
						has_close          = 1'b1;
						close_r.token_kind = cts_pkg::keyword_kind(
							ctx.keyword_window, ctx.pending_length);
						rescan             = 1'b1;
					end
				end
				cts_pkg::ST_INT: begin
					if (c == cts_pkg::CH_DOT) begin
						nxt.scan_state     = cts_pkg::ST_FLOAT;
						nxt.pending_length = cts_pkg::cnt_inc(ctx.pending_length);
					end else if (cts_pkg::is_digit(c)) begin
						nxt.pending_length = cts_pkg::cnt_inc(ctx.pending_length);
					end else begin
						has_close          = 1'b1;
						close_r.token_kind = cts_pkg::KIND_INT;
						rescan             = 1'b1;
					end
				end
				cts_pkg::ST_FLOAT: begin
					if (cts_pkg::is_digit(c)) begin
						nxt.pending_length = cts_pkg::cnt_inc(ctx.pending_length);
					end else begin
						has_close          = 1'b1;
						close_r.token_kind = cts_pkg::KIND_FLOAT;
						rescan             = 1'b1;
					end
				end
				cts_pkg::ST_STRING: begin
					if (c == cts_pkg::CH_QUOTE) begin
						has_close          = 1'b1;
						close_r.token_kind = cts_pkg::KIND_STRING;
						nxt.scan_state     = cts_pkg::ST_INIT;
					end else begin
						nxt.pending_length = cts_pkg::cnt_inc(ctx.pending_length);
					end
				end
				cts_pkg::ST_DOT: begin
					if (c == cts_pkg::CH_DOT) begin
						nxt.scan_state     = cts_pkg::ST_DOTDOT;
						nxt.pending_length = cts_pkg::cnt_t'(2);
					end else begin
						has_close          = 1'b1;
						close_r.token_kind = cts_pkg::KIND_DOT;
						rescan             = 1'b1;
					end
				end
				cts_pkg::ST_DOTDOT: begin
					has_close      = 1'b1;
					nxt.scan_state = cts_pkg::ST_INIT;
					if (c == cts_pkg::CH_DOT) begin
						close_r.token_kind   = cts_pkg::KIND_ELLIPSIS;
						close_r.token_length = cts_pkg::cnt_t'(3);
					end else begin
						close_r.error_code = cts_pkg::ERR_DOUBLE_DOT;
						rescan             = 1'b1;
					end
				end
				cts_pkg::ST_BANG: begin
					has_close      = 1'b1;
					nxt.scan_state = cts_pkg::ST_INIT;
					if (c == cts_pkg::CH_EQUAL) begin
						close_r.token_kind   = cts_pkg::KIND_NOTEQ;
						close_r.token_length = cts_pkg::cnt_t'(2);
					end else begin
						close_r.error_code = cts_pkg::ERR_BANG;
						rescan             = 1'b1;
					end
				end
				default: begin
					rescan = 1'b1;
				end
			endcase

			if (rescan) begin
				nxt.scan_state     = cts_pkg::ST_INIT;
				nxt.pending_start  = ctx.byte_position;
				nxt.pending_length = cts_pkg::cnt_t'(1);
				nxt.pending_line   = ctx.line_counter;
				nxt.pending_column = ctx.column_counter;
				priority if (cts_pkg::is_space(c)) begin
					nxt.pending_start  = ctx.pending_start;
					nxt.pending_length = ctx.pending_length;
					nxt.pending_line   = ctx.pending_line;
					nxt.pending_column = ctx.pending_column;
					if (has_close) begin
						nxt.pending_length = close_r.token_length;
					end
				end else if (cts_pkg::is_alpha(c)) begin
					nxt.scan_state     = cts_pkg::ST_IDENT;
					nxt.keyword_window = {{(cts_pkg::WINDOW_BITS-8){1'b0}}, c};
				end else if (cts_pkg::is_digit(c)) begin
					nxt.scan_state = cts_pkg::ST_INT;
				end else if (c == cts_pkg::CH_QUOTE) begin
					nxt.scan_state     = cts_pkg::ST_STRING;
					nxt.pending_start  = cts_pkg::pos_inc(ctx.byte_position);
					nxt.pending_length = '0;
				end else if (c == cts_pkg::CH_DOT) begin
					nxt.scan_state = cts_pkg::ST_DOT;
				end else if (c == cts_pkg::CH_BANG) begin
					nxt.scan_state = cts_pkg::ST_BANG;
				end else if (sk != cts_pkg::KIND_IDENT) begin
					nxt.pending_start  = ctx.pending_start;
					nxt.pending_length = has_close ? close_r.token_length : ctx.pending_length;
					nxt.pending_line   = ctx.pending_line;
					nxt.pending_column = ctx.pending_column;
					has_init           = 1'b1;
					init_r.token_kind  = sk;
				end else begin
					nxt.pending_start  = ctx.pending_start;
					nxt.pending_length = has_close ? close_r.token_length : ctx.pending_length;
					nxt.pending_line   = ctx.pending_line;
					nxt.pending_column = ctx.pending_column;
					has_init           = 1'b1;
					init_r.error_code  = cts_pkg::ERR_UNEXPECTED;
				end
			end else if (has_close) begin
				nxt.pending_length = close_r.token_length;
			end

			nxt.byte_position = cts_pkg::pos_inc(ctx.byte_position);
			if (c == cts_pkg::CH_NEWLINE) begin
				nxt.line_counter   = cts_pkg::cnt_inc(ctx.line_counter);
				nxt.column_counter = cts_pkg::cnt_t'(1);
			end else begin
				nxt.column_counter = cts_pkg::cnt_inc(ctx.column_counter);
			end
		end

		// pack close result ahead of the rescan result
		result.count  = {1'b0, has_close} + {1'b0, has_init};
		result.first  = has_close ? close_r : init_r;
		result.second = init_r;
		if (has_close && has_init) begin
			result.second.last_of_run = 1'b1;
		end else begin
			result.first.last_of_run = 1'b1;
		end
		ctx_next = nxt;
	end

endmodule

`default_nettype wire

>>> design/c_subset_token_scanner.sv
// c_subset_token_scanner: top level of the c-subset token scanner
// input register, one-pass scan core and a two-slot result register
// depends on cts_pkg and cts_scan_core
`default_nettype none

//  channel | handshake            | payload
//  src     | src_valid/src_ready  | src_data : cts_pkg::src_req_t (one byte or end mark)
//  tok     | tok_valid/tok_ready  | tok_data : cts_pkg::tok_req_t (one token)
//
//  one request per cycle while each request yields at most one token and tok_ready is high;
//  after a request that yields two tokens the next token-producing request waits while the
//  pair drains; once its request is taken a token passes the input register, then the result register
//  reset restores the scanner context and counters and clears both valid flags at once
//  a stalled tok side fills the result slots, then the input register, then drops src_ready

module c_subset_token_scanner (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   src_valid,
	output logic                  src_ready,
	input  wire cts_pkg::src_req_t src_data,
	output logic                  tok_valid,
	input  wire                   tok_ready,
	output cts_pkg::tok_req_t     tok_data
);

	cts_pkg::src_req_t    item_s1;
	logic                 valid_s1;
	cts_pkg::scan_ctx_t   ctx_q;
	cts_pkg::scan_ctx_t   ctx_next;
	cts_pkg::scan_result_t res;
	cts_pkg::tok_req_t    head_q;
	cts_pkg::tok_req_t    tail_q;
	logic [1:0]           cnt_q;
	logic                 tok_fire;
	logic                 room;
	logic                 load;

	cts_scan_core u_core (
		.ctx      (ctx_q),
		.item     (item_s1),
		.ctx_next (ctx_next),
		.result   (res)
	);

	assign tok_valid = (cnt_q != 2'd0);
	assign tok_data  = head_q;
	assign tok_fire  = tok_valid && tok_ready;
	assign room      = (res.count == 2'd0) || (cnt_q == 2'd0) || (cnt_q == 2'd1 && tok_fire);
	assign load      = valid_s1 && room;
	assign src_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			item_s1 <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.scan_state     <= cts_pkg::ST_INIT;
			ctx_q.pending_start  <= '0;
			ctx_q.pending_length <= '0;
			ctx_q.pending_line   <= cts_pkg::cnt_t'(1);
			ctx_q.pending_column <= cts_pkg::cnt_t'(1);
			ctx_q.keyword_window <= '0;
			ctx_q.byte_position  <= '0;
			ctx_q.line_counter   <= cts_pkg::cnt_t'(1);
			ctx_q.column_counter <= cts_pkg::cnt_t'(1);
		end else if (load) begin
			ctx_q <= ctx_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && res.count != 2'd0) begin
			cnt_q <= res.count;
		end else if (tok_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.count != 2'd0) begin
			head_q <= res.first;
			tail_q <= res.second;
		end else if (tok_fire) begin
			head_q <= tail_q;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking bench for c_subset_token_scanner, one source byte or end mark per request
// predicts every token from its own scanner state and checks each token field by field
// depends on cts_pkg and the c_subset_token_scanner rtl
`timescale 1ns / 1ps

module tb;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              src_valid = 1'b0;
	logic              src_ready;
	cts_pkg::src_req_t src_data  = '0;
	logic              tok_valid;
	logic              tok_ready = 1'b0;
	cts_pkg::tok_req_t tok_data;

	c_subset_token_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// scanner state mirror
	cts_pkg::scan_state_t lx_state   = cts_pkg::ST_INIT;
	cts_pkg::pos_t        lx_start   = '0;
	cts_pkg::cnt_t        lx_len     = '0;
	cts_pkg::cnt_t        lx_line    = cts_pkg::cnt_t'(1);
	cts_pkg::cnt_t        lx_col     = cts_pkg::cnt_t'(1);
	cts_pkg::window_t     lx_window  = '0;
	cts_pkg::pos_t        lx_pos     = '0;
	cts_pkg::cnt_t        lx_linecnt = cts_pkg::cnt_t'(1);
	cts_pkg::cnt_t        lx_colcnt  = cts_pkg::cnt_t'(1);

	cts_pkg::tok_req_t    step_tokens [$];
	cts_pkg::tok_req_t    tokens_due [$];
	cts_pkg::src_req_t    source_items [$];
	string                single_set = "(){},;+=*&<>-[]/";

	int          bad_tokens    = 0;
	int          requests_sent = 0;
	int          stall_left    = 0;
	bit          src_idle_on   = 1'b1;
	bit          sink_idle_on  = 1'b1;

	function automatic cts_pkg::pos_t bump_pos(cts_pkg::pos_t v);
		return (v == cts_pkg::POS_MAX) ? v : v + cts_pkg::pos_t'(1);
	endfunction

	function automatic cts_pkg::cnt_t bump_cnt(cts_pkg::cnt_t v);
		return (v == cts_pkg::CNT_MAX) ? v : v + cts_pkg::cnt_t'(1);
	endfunction

	function automatic bit letter_byte(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_byte(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit blank_byte(logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic string keyword_text(int k);
		case (k)
			0:       return "const";
			1:       return "return";
			2:       return "if";
			3:       return "while";
			4:       return "typedef";
			5:       return "struct";
			6:       return "unsigned";
			default: return "enum";
		endcase
	endfunction

	function automatic cts_pkg::kind_t ident_kind();
		string w;
		bit    same;
		for (int k = 0; k < cts_pkg::KEYWORDS; k++) begin
			w = keyword_text(k);
			same = (int'(lx_len) == w.len());
			for (int i = 0; same && i < w.len(); i++) begin
				if (lx_window[8*i +: 8] != w[i]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				return cts_pkg::KIND_KW_BASE + cts_pkg::kind_t'(k);
			end
		end
		return cts_pkg::KIND_IDENT;
	endfunction

	function automatic void emit(cts_pkg::kind_t kind, cts_pkg::pos_t start, cts_pkg::cnt_t len,
		cts_pkg::cnt_t line, cts_pkg::cnt_t col, cts_pkg::err_t err);
		cts_pkg::tok_req_t t;
		t.token_kind    = kind;
		t.start_index   = start;
		t.token_length  = len;
		t.line_number   = line;
		t.column_number = col;
		t.error_code    = err;
		t.last_of_run   = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void emit_pending(cts_pkg::kind_t kind, cts_pkg::err_t err);
		emit(kind, lx_start, lx_len, lx_line, lx_col, err);
	endfunction

	function automatic void open_token(cts_pkg::scan_state_t st, cts_pkg::pos_t start,
		cts_pkg::cnt_t len);
		lx_state = st;
		lx_start = start;
		lx_len   = len;
		lx_line  = lx_linecnt;
		lx_col   = lx_colcnt;
	endfunction

	function automatic void lex_fresh(logic [7:0] c);
		int hit;
		hit = -1;
		lx_state = cts_pkg::ST_INIT;
		if (blank_byte(c)) begin
		end else if (letter_byte(c)) begin
			open_token(cts_pkg::ST_IDENT, lx_pos, cts_pkg::cnt_t'(1));
			lx_window = cts_pkg::window_t'(c);
		end else if (digit_byte(c)) begin
			open_token(cts_pkg::ST_INT, lx_pos, cts_pkg::cnt_t'(1));
		end else if (c == cts_pkg::CH_QUOTE) begin
			open_token(cts_pkg::ST_STRING, bump_pos(lx_pos), '0);
		end else if (c == cts_pkg::CH_DOT) begin
			open_token(cts_pkg::ST_DOT, lx_pos, cts_pkg::cnt_t'(1));
		end else if (c == cts_pkg::CH_BANG) begin
			open_token(cts_pkg::ST_BANG, lx_pos, cts_pkg::cnt_t'(1));
		end else begin
			for (int i = 0; i < 16; i++) begin
				if (hit < 0 && single_set[i] == c) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				emit(cts_pkg::KIND_SINGLE + cts_pkg::kind_t'(hit), lx_pos, cts_pkg::cnt_t'(1),
					lx_linecnt, lx_colcnt, cts_pkg::ERR_NONE);
			end else begin
				emit(cts_pkg::KIND_IDENT, lx_pos, cts_pkg::cnt_t'(1), lx_linecnt, lx_colcnt,
					cts_pkg::ERR_UNEXPECTED);
			end
		end
	endfunction

	// returns 1 when the byte closed a token and must be scanned again
	function automatic bit lex_byte(logic [7:0] c);
		bit again;
		again = 1'b0;
		case (lx_state)
			cts_pkg::ST_IDENT: begin
				if (letter_byte(c) || digit_byte(c) || c == cts_pkg::CH_UNDER) begin
					if (lx_len < cts_pkg::cnt_t'(cts_pkg::KEYWORD_CHARS)) begin
						lx_window[8*int'(lx_len) +: 8] = c;
					end
					lx_len = bump_cnt(lx_len);
				end else begin
					emit_pending(ident_kind(), cts_pkg::ERR_NONE);
					lx_state = cts_pkg::ST_INIT;
					again = 1'b1;
				end
			end
			cts_pkg::ST_INT, cts_pkg::ST_FLOAT: begin
				if (lx_state == cts_pkg::ST_INT && c == cts_pkg::CH_DOT) begin
					lx_state = cts_pkg::ST_FLOAT;
					lx_len = bump_cnt(lx_len);
				end else if (digit_byte(c)) begin
					lx_len = bump_cnt(lx_len);
				end else begin
					emit_pending(lx_state == cts_pkg::ST_INT ? cts_pkg::KIND_INT
						: cts_pkg::KIND_FLOAT, cts_pkg::ERR_NONE);
					lx_state = cts_pkg::ST_INIT;
					again = 1'b1;
				end
			end
			cts_pkg::ST_STRING: begin
				if (c == cts_pkg::CH_QUOTE) begin
					emit_pending(cts_pkg::KIND_STRING, cts_pkg::ERR_NONE);
					lx_state = cts_pkg::ST_INIT;
				end else begin
					lx_len = bump_cnt(lx_len);
				end
			end
			cts_pkg::ST_DOT: begin
				if (c == cts_pkg::CH_DOT) begin
					lx_state = cts_pkg::ST_DOTDOT;
					lx_len = cts_pkg::cnt_t'(2);
				end else begin
					emit_pending(cts_pkg::KIND_DOT, cts_pkg::ERR_NONE);
					lx_state = cts_pkg::ST_INIT;
					again = 1'b1;
				end
			end
			cts_pkg::ST_DOTDOT: begin
				lx_state = cts_pkg::ST_INIT;
				if (c == cts_pkg::CH_DOT) begin
					lx_len = cts_pkg::cnt_t'(3);
					emit_pending(cts_pkg::KIND_ELLIPSIS, cts_pkg::ERR_NONE);
				end else begin
					emit_pending(cts_pkg::KIND_IDENT, cts_pkg::ERR_DOUBLE_DOT);
					again = 1'b1;
				end
			end
			cts_pkg::ST_BANG: begin
				lx_state = cts_pkg::ST_INIT;
				if (c == cts_pkg::CH_EQUAL) begin
					lx_len = cts_pkg::cnt_t'(2);
					emit_pending(cts_pkg::KIND_NOTEQ, cts_pkg::ERR_NONE);
				end else begin
					emit_pending(cts_pkg::KIND_IDENT, cts_pkg::ERR_BANG);
					again = 1'b1;
				end
			end
			default: lex_fresh(c);
		endcase
		return again;
	endfunction

	function automatic void predict_tokens(cts_pkg::src_req_t r);
		step_tokens.delete();
		if (r.end_of_input) begin
			case (lx_state)
				cts_pkg::ST_IDENT:  emit_pending(ident_kind(), cts_pkg::ERR_NONE);
				cts_pkg::ST_INT:    emit_pending(cts_pkg::KIND_INT, cts_pkg::ERR_NONE);
				cts_pkg::ST_FLOAT:  emit_pending(cts_pkg::KIND_FLOAT, cts_pkg::ERR_NONE);
				cts_pkg::ST_STRING: emit_pending(cts_pkg::KIND_IDENT, cts_pkg::ERR_OPEN_STR);
				cts_pkg::ST_DOT:    emit_pending(cts_pkg::KIND_DOT, cts_pkg::ERR_NONE);
				cts_pkg::ST_DOTDOT: emit_pending(cts_pkg::KIND_IDENT, cts_pkg::ERR_DOUBLE_DOT);
				cts_pkg::ST_BANG:   emit_pending(cts_pkg::KIND_IDENT, cts_pkg::ERR_BANG);
				default: ;
			endcase
			lx_state = cts_pkg::ST_INIT;
			emit(cts_pkg::KIND_END, lx_pos, '0, lx_linecnt, lx_colcnt, cts_pkg::ERR_NONE);
		end else begin
			if (lex_byte(r.char_code)) begin
				void'(lex_byte(r.char_code));
			end
			lx_pos = bump_pos(lx_pos);
			if (r.char_code == cts_pkg::CH_NEWLINE) begin
				lx_linecnt = bump_cnt(lx_linecnt);
				lx_colcnt  = cts_pkg::cnt_t'(1);
			end else begin
				lx_colcnt = bump_cnt(lx_colcnt);
			end
		end
		if (step_tokens.size() > 0) begin
			step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
		end
		foreach (step_tokens[i]) begin
			tokens_due.push_back(step_tokens[i]);
		end
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	task automatic send_item(input cts_pkg::src_req_t r);
		int gap;
		gap = src_idle_on ? pick_pause() : 0;
		@(negedge clk);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= r;
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		predict_tokens(r);
		requests_sent++;
	endtask

	function automatic void push_char(logic [7:0] c);
		cts_pkg::src_req_t r;
		r.char_code    = c;
		r.end_of_input = 1'b0;
		source_items.push_back(r);
	endfunction

	function automatic void push_end();
		cts_pkg::src_req_t r;
		r.char_code    = 8'($urandom_range(0, 255));
		r.end_of_input = 1'b1;
		source_items.push_back(r);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i]);
		end
	endfunction

	task automatic send_queued();
		while (source_items.size() > 0) begin
			send_item(source_items.pop_front());
		end
	endtask

	// sender holds off until every predicted token is out
	task automatic drain();
		@(negedge clk);
		src_valid <= 1'b0;
		while (tokens_due.size() > 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] pick_word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 52) begin
			return pick_letter();
		end
		return (r < 62) ? 8'("0" + r - 52) : cts_pkg::CH_UNDER;
	endfunction

	function automatic logic [7:0] pick_blank();
		int r;
		r = $urandom_range(0, 6);
		return (r == 6) ? 8'h20 : 8'(9 + (r % 5));
	endfunction

	function automatic void push_digits(int n);
		for (int i = 0; i < n; i++) begin
			push_char(8'("0" + $urandom_range(0, 9)));
		end
	endfunction

	function automatic void add_random_lexeme();
		int          pick;
		int          n;
		string       w;
		logic [7:0]  c;
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			w = keyword_text($urandom_range(0, 7));
			n = $urandom_range(0, 3);
			for (int i = 0; i < w.len() - (n == 1 ? 1 : 0); i++) begin
				push_char(w[i]);
			end
			if (n == 2) begin
				push_char(pick_word_char());
			end
		end else if (pick < 30) begin
			push_char(pick_letter());
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
			for (int i = 0; i < n; i++) begin
				push_char(pick_word_char());
			end
		end else if (pick < 45) begin
			push_digits($urandom_range(1, 4));
			if ($urandom_range(0, 99) < 40) begin
				push_char(cts_pkg::CH_DOT);
				push_digits($urandom_range(0, 3));
				if ($urandom_range(0, 99) < 15) begin
					push_char(cts_pkg::CH_DOT);
				end
			end
		end else if (pick < 55) begin
			push_char(cts_pkg::CH_QUOTE);
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) begin
				c = 8'($urandom_range(0, 255));
				if (c == cts_pkg::CH_QUOTE) begin
					c = cts_pkg::CH_NEWLINE;
				end
				push_char(c);
			end
			if ($urandom_range(0, 9) != 0) begin
				push_char(cts_pkg::CH_QUOTE);
			end
		end else if (pick < 70) begin
			push_char(single_set[$urandom_range(0, 15)]);
		end else if (pick < 80) begin
			case ($urandom_range(0, 4))
				0:       push_text(".");
				1:       push_text("..");
				2:       push_text("...");
				3:       push_text("!");
				default: push_text("!=");
			endcase
		end else if (pick < 90) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				push_char(pick_blank());
			end
		end else if (pick < 98) begin
			push_char(8'($urandom_range(0, 255)));
		end else begin
			push_end();
		end
		if ($urandom_range(0, 1) == 0) begin
			push_char(pick_blank());
		end
	endfunction

	always @(negedge clk) begin
		if (stall_left == 0 && sink_idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_pause();
		end
		if (stall_left > 0) begin
			tok_ready <= 1'b0;
			stall_left--;
		end else begin
			tok_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cts_pkg::tok_req_t want;
		if (arst_n && tok_valid && tok_ready) begin
			if (tokens_due.size() == 0) begin
				bad_tokens++;
				if (bad_tokens <= 10) begin
					$display("unexpected token: kind %0d start %0d len %0d err %0d",
						tok_data.token_kind, tok_data.start_index, tok_data.token_length,
						tok_data.error_code);
				end
			end else begin
				want = tokens_due.pop_front();
				if (tok_data.token_kind !== want.token_kind ||
					tok_data.start_index !== want.start_index ||
					tok_data.token_length !== want.token_length ||
					tok_data.line_number !== want.line_number ||
					tok_data.column_number !== want.column_number ||
					tok_data.error_code !== want.error_code ||
					tok_data.last_of_run !== want.last_of_run) begin
					bad_tokens++;
					if (bad_tokens <= 10) begin
						$display("token mismatch: expected kind %0d start %0d len %0d line %0d",
							want.token_kind, want.start_index, want.token_length,
							want.line_number, " col %0d err %0d last %0d",
							want.column_number, want.error_code, want.last_of_run);
						$display("                got      kind %0d start %0d len %0d line %0d",
							tok_data.token_kind, tok_data.start_index, tok_data.token_length,
							tok_data.line_number, " col %0d err %0d last %0d",
							tok_data.column_number, tok_data.error_code, tok_data.last_of_run);
					end
				end
			end
		end
	end

	task automatic test_end_after_reset();
		push_end();
		send_queued();
		drain();
	endtask

	// keyword closed by a bang, not-equal, lone bang, ellipsis, float ended by a dot, double dot
	task automatic test_operators_and_rescan();
		push_text("if!=!x...1.2..y");
		push_end();
		send_queued();
		drain();
	endtask

	task automatic test_flush_at_end();
		push_text("\"a\nb");
		push_end();
		push_text("!");
		push_end();
		push_text("..");
		push_end();
		push_text("7.");
		push_end();
		send_queued();
		drain();
	endtask

	task automatic test_bad_bytes();
		push_char(8'h00);
		push_char(cts_pkg::CH_UNDER);
		push_char(8'h80);
		push_char(8'hff);
		push_char(8'h09);
		push_text("a_1");
		push_end();
		send_queued();
		drain();
	endtask

	task automatic test_random_source();
		int target;
		target = requests_sent + 1450;
		while (requests_sent < target) begin
			if ($urandom_range(0, 39) == 0) begin
				src_idle_on  = ($urandom_range(0, 3) != 0);
				sink_idle_on = ($urandom_range(0, 3) != 0);
			end
			add_random_lexeme();
			send_queued();
			if ($urandom_range(0, 99) == 0) begin
				drain();
			end
		end
		push_end();
		send_queued();
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_end_after_reset();
		test_operators_and_rescan();
		test_flush_at_end();
		test_bad_bytes();
		test_random_source();
		repeat (20) @(posedge clk);
		if (bad_tokens == 0 && tokens_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
design/cts_pkg.sv
design/cts_scan_core.sv
design/c_subset_token_scanner.sv
tb/tb.sv
